/* rtl/mqrb_pkg.sv */
// mqrb_pkg: shared types, constants and register indexes for the
// multi-queue ring buffer pool. No dependencies.
package mqrb_pkg;

  localparam int NUM_QUEUES = 4;
  localparam int POOL_DEPTH = 128;
  localparam int CODE_BITS  = 8;

  localparam int SIZE_W   = 8;                          // size register width
  localparam int QID_W    = 2;                          // queue_id field width
  localparam int ADDR_W   = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W    = $clog2(POOL_DEPTH + 1);     // fill count, 0..POOL_DEPTH
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_SIZE_0 = 3'd0;
  localparam int                   SIZE_REGS        = 4;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_CODE   = 3'd4;

  localparam logic [CODE_BITS-1:0] EMPTY_CODE_RST = '1;

  typedef enum logic [0:0] {
    FUNC_PUT = 1'b0,
    FUNC_GET = 1'b1
  } func_t;

  typedef struct packed {
    func_t                func;
    logic [QID_W-1:0]     queue_id;
    logic [CODE_BITS-1:0] write_code;
  } in_item_t;

  typedef struct packed {
    logic [CODE_BITS-1:0] read_code;
    logic                 done_res;
  } out_item_t;

  // carved pool layout, one entry per slot
  typedef struct packed {
    logic [NUM_QUEUES-1:0]             en;
    logic [NUM_QUEUES-1:0][ADDR_W-1:0] base;
    logic [NUM_QUEUES-1:0][SIZE_W-1:0] size;
  } layout_t;

  typedef struct packed {
    logic             fire;
    func_t            func;
    logic [QID_W-1:0] queue_id;
  } qs_req_t;

  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] addr;
  } qs_resp_t;

endpackage

/* rtl/mqrb_layout.sv */
// mqrb_layout: configuration registers and the registered pool carving
// (enable and base per slot). Depends on mqrb_pkg.
module mqrb_layout (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mqrb_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [mqrb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output mqrb_pkg::layout_t                   layout,
  output logic [mqrb_pkg::CODE_BITS-1:0]      empty_code,
  output logic                                clear
);

  logic [mqrb_pkg::NUM_QUEUES-1:0][mqrb_pkg::SIZE_W-1:0] size_r;
  logic [mqrb_pkg::CODE_BITS-1:0]                         empty_code_r;
  logic [mqrb_pkg::NUM_QUEUES-1:0]                        en_r, en_nxt;
  logic [mqrb_pkg::NUM_QUEUES-1:0][mqrb_pkg::ADDR_W-1:0]  base_r, base_nxt;
  logic [mqrb_pkg::SIZE_W:0]                              used_v;
  logic [mqrb_pkg::SIZE_W:0]                              room_v;
  logic                                                   size_wr;

  // size write to an existing slot clears all queue state
  assign size_wr = cfg_we &&
                   (32'(cfg_idx) < mqrb_pkg::SIZE_REGS) &&
                   (32'(cfg_idx) < mqrb_pkg::NUM_QUEUES);
  assign clear = size_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r       <= '0;
      empty_code_r <= mqrb_pkg::EMPTY_CODE_RST;
    end else if (cfg_we) begin
      for (int i = 0; i < mqrb_pkg::NUM_QUEUES; i++) begin
        if (size_wr && (32'(cfg_idx) == i)) begin
          size_r[i] <= cfg_wdata[mqrb_pkg::SIZE_W-1:0];
        end
      end
      if (cfg_idx == mqrb_pkg::REG_EMPTY_CODE) begin
        empty_code_r <= cfg_wdata[mqrb_pkg::CODE_BITS-1:0];
      end
    end
  end

  // slots are carved in order; a slot that does not fit takes no space
  always_comb begin
    used_v   = '0;
    room_v   = '0;
    en_nxt   = '0;
    base_nxt = '0;
    for (int i = 0; i < mqrb_pkg::NUM_QUEUES; i++) begin
      room_v      = (mqrb_pkg::SIZE_W+1)'(mqrb_pkg::POOL_DEPTH) - used_v;
      base_nxt[i] = used_v[mqrb_pkg::ADDR_W-1:0];
      en_nxt[i]   = (size_r[i] != '0) && ({1'b0, size_r[i]} <= room_v);
      if (en_nxt[i]) begin
        used_v = used_v + {1'b0, size_r[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= '0;
      base_r <= '0;
    end else begin
      en_r   <= en_nxt;
      base_r <= base_nxt;
    end
  end

  assign layout.en   = en_r;
  assign layout.base = base_r;
  assign layout.size = size_r;
  assign empty_code  = empty_code_r;

endmodule

/* rtl/mqrb_qstate.sv */
// mqrb_qstate: per-queue write/read pointers and fill counts; decides
// whether a put or get succeeds and forms its pool address. Depends on mqrb_pkg.
module mqrb_qstate (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clear,
  input  mqrb_pkg::layout_t  layout,
  input  mqrb_pkg::qs_req_t  req,
  output mqrb_pkg::qs_resp_t resp
);

  logic [mqrb_pkg::NUM_QUEUES-1:0][mqrb_pkg::ADDR_W-1:0] wp_r, wp_nxt;
  logic [mqrb_pkg::NUM_QUEUES-1:0][mqrb_pkg::ADDR_W-1:0] rp_r, rp_nxt;
  logic [mqrb_pkg::NUM_QUEUES-1:0][mqrb_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;

  logic                        sel_en;
  logic [mqrb_pkg::ADDR_W-1:0] sel_base;
  logic [mqrb_pkg::SIZE_W-1:0] sel_size;
  logic [mqrb_pkg::ADDR_W-1:0] sel_wp;
  logic [mqrb_pkg::ADDR_W-1:0] sel_rp;
  logic [mqrb_pkg::CNT_W-1:0]  sel_cnt;
  logic [mqrb_pkg::ADDR_W-1:0] sel_ptr;
  logic [mqrb_pkg::ADDR_W-1:0] ptr_adv;
  logic [mqrb_pkg::SIZE_W:0]   ptr_inc;
  logic                        put_ok;
  logic                        get_ok;
  logic                        is_get;

  assign is_get = (req.func == mqrb_pkg::FUNC_GET);

  always_comb begin
    sel_en   = 1'b0;
    sel_base = '0;
    sel_size = '0;
    sel_wp   = '0;
    sel_rp   = '0;
    sel_cnt  = '0;
    for (int i = 0; i < mqrb_pkg::NUM_QUEUES; i++) begin
      if (32'(req.queue_id) == i) begin
        sel_en   = layout.en[i];
        sel_base = layout.base[i];
        sel_size = layout.size[i];
        sel_wp   = wp_r[i];
        sel_rp   = rp_r[i];
        sel_cnt  = cnt_r[i];
      end
    end
  end

  assign put_ok  = sel_en && !is_get && (mqrb_pkg::SIZE_W'(sel_cnt) < sel_size);
  assign get_ok  = sel_en && is_get && (sel_cnt != '0);
  assign sel_ptr = is_get ? sel_rp : sel_wp;

  // wrap by compare with the queue size
  assign ptr_inc = (mqrb_pkg::SIZE_W+1)'(sel_ptr) + 1'b1;
  assign ptr_adv = (ptr_inc >= {1'b0, sel_size}) ? '0 : ptr_inc[mqrb_pkg::ADDR_W-1:0];

  assign resp.done = put_ok || get_ok;
  assign resp.addr = sel_base + sel_ptr;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    for (int i = 0; i < mqrb_pkg::NUM_QUEUES; i++) begin
      if (req.fire && (32'(req.queue_id) == i)) begin
        if (put_ok) begin
          wp_nxt[i]  = ptr_adv;
          cnt_nxt[i] = cnt_r[i] + 1'b1;
        end
        if (get_ok) begin
          rp_nxt[i]  = ptr_adv;
          cnt_nxt[i] = cnt_r[i] - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/multi_queue_ring_buffer_pool.sv */
// multi_queue_ring_buffer_pool: top level. Input register, queue state,
// shared code pool memory and result register. Depends on mqrb_pkg,
// mqrb_layout and mqrb_qstate.
//
//   channel | ports                         | payload
//   --------+-------------------------------+------------------------------
//   input   | in_valid / in_ready / in_data | func, queue_id, write_code
//   result  | out_valid / out_ready / out_data | read_code, done_res
//   config  | cfg_we / cfg_idx / cfg_wdata  | sizes 0..3, empty_code
//
// One transaction per cycle sustained while out_ready is held high. A
// transaction sits in the input register, where the queue pointers are
// looked up and updated and the pool is written (put) or read (get); the
// registered pool read is the result register, so out_valid rises when the
// transaction moves from the input register into the result register.
// Reset clears all pointers and counts; pool contents are undefined until
// written and need no clearing. A stalled result holds the input register,
// which in turn drops in_ready once it is full.
module multi_queue_ring_buffer_pool (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  mqrb_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mqrb_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [mqrb_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [mqrb_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  mqrb_pkg::layout_t              layout;
  logic [mqrb_pkg::CODE_BITS-1:0] empty_code;
  logic                           clear;
  mqrb_pkg::qs_req_t              qs_req;
  mqrb_pkg::qs_resp_t             qs_resp;

  // stage 1: accepted transaction
  logic               s1_valid_r;
  mqrb_pkg::in_item_t s1_item_r;
  logic               adv;

  // result stage
  logic                           out_valid_r;
  logic                           out_done_r;
  logic                           out_sel_r;   // 1: answer comes from the pool
  logic [mqrb_pkg::CODE_BITS-1:0] rd_data_r;

  logic [mqrb_pkg::CODE_BITS-1:0] pool_mem [mqrb_pkg::POOL_DEPTH];
  logic                           do_put;
  logic                           do_get;

  mqrb_layout u_layout (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .layout     (layout),
    .empty_code (empty_code),
    .clear      (clear)
  );

  // stage 1 advances when the result register is free or being drained
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
  end

  assign qs_req.fire     = adv;
  assign qs_req.func     = s1_item_r.func;
  assign qs_req.queue_id = s1_item_r.queue_id;

  mqrb_qstate u_qstate (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (clear),
    .layout(layout),
    .req   (qs_req),
    .resp  (qs_resp)
  );

  assign do_put = adv && qs_resp.done && (s1_item_r.func == mqrb_pkg::FUNC_PUT);
  assign do_get = adv && qs_resp.done && (s1_item_r.func == mqrb_pkg::FUNC_GET);

  // shared code pool: one port, either a put write or a get read per cycle
  always_ff @(posedge clk) begin
    if (do_put) begin
      pool_mem[qs_resp.addr] <= s1_item_r.write_code;
    end
    if (do_get) begin
      rd_data_r <= pool_mem[qs_resp.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_done_r  <= 1'b0;
      out_sel_r   <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
      out_done_r  <= qs_resp.done;
      out_sel_r   <= do_get;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // a put or a failed get answers with empty_code
  assign out_valid          = out_valid_r;
  assign out_data.read_code = out_sel_r ? rd_data_r : empty_code;
  assign out_data.done_res  = out_done_r;

endmodule
